@@ hw/rtl/cosa_pkg.sv @@
// ----------------------------------------------------------------------------
// cosa_pkg
// Shared types and constants for the cosine similarity argmax core.
// ----------------------------------------------------------------------------
package cosa_pkg;

    localparam int NUM_FIELDS   = 4;
    localparam int ELEM_W       = 16;
    localparam int IDX_W        = 8;
    localparam int DEF_VEC_DIM  = 4;
    localparam int DEF_MAX_CAND = 256;
    localparam int SQRT_STEPS   = 17;
    localparam int DIV_STEPS    = 17;
    localparam int CNT_W        = 5;

    localparam logic [2:0] CFG_DIMS = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQI,
        ST_SQRT,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       acc;
        logic [1:0] acc_sel;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       mul;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] n_use;
    } t_dp_stat;

endpackage

@@ hw/rtl/cosa_ctrl.sv @@
// ----------------------------------------------------------------------------
// cosa_ctrl
// Sequencer for accumulation, square roots, product, division and commit.
// ----------------------------------------------------------------------------
module cosa_ctrl
    import cosa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_stat.n_use != 3'd0) ? ST_ACC : ST_SQI;
                end
            end
            ST_ACC: begin
                o_cmd.acc     = 1'b1;
                o_cmd.acc_sel = r_cnt[1:0];
                if (r_cnt == CNT_W'(i_stat.n_use - 3'd1)) begin
                    n_cnt   = '0;
                    n_state = ST_SQI;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt           = '0;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIN: begin
                // The result register may only be overwritten once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = o_cmd.commit | (r_out_valid & i_out_stall);
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted a transaction while busy");
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("commit did not raise output valid");
    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("division counter out of range");
`endif

endmodule

@@ hw/rtl/cosa_dp.sv @@
// ----------------------------------------------------------------------------
// cosa_dp
// Datapath: query registers, dot and norm accumulators, two square root
// units, root product, radix-2 divider and the running argmax.
// ----------------------------------------------------------------------------
module cosa_dp
    import cosa_pkg::*;
#(
    parameter int VEC_DIM        = DEF_VEC_DIM,
    parameter int MAX_CANDIDATES = DEF_MAX_CAND
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [ELEM_W-1:0]        i_cfg_data,
    input  logic signed [ELEM_W-1:0] i_cand_elem_0,
    input  logic signed [ELEM_W-1:0] i_cand_elem_1,
    input  logic signed [ELEM_W-1:0] i_cand_elem_2,
    input  logic signed [ELEM_W-1:0] i_cand_elem_3,
    input  logic                     i_last_candidate,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    output logic signed [ELEM_W-1:0] o_similarity,
    output logic [IDX_W-1:0]         o_cand_index,
    output logic                     o_run_done,
    output logic [IDX_W-1:0]         o_best_index,
    output logic                     o_best_found
);

    localparam int DIM_LIM = (VEC_DIM < NUM_FIELDS) ? VEC_DIM : NUM_FIELDS;
    localparam int IDX_LIM = (MAX_CANDIDATES - 1 < 255) ? MAX_CANDIDATES - 1 : 255;
    localparam int REM_W   = 20;

    logic signed [ELEM_W-1:0] r_query [NUM_FIELDS];
    logic [2:0]               r_dims;
    logic signed [ELEM_W-1:0] r_cand [NUM_FIELDS];
    logic                     r_last;

    logic signed [33:0] r_dot;
    logic [32:0]        r_sum [2];
    logic [33:0]        r_sq_src [2];
    logic [REM_W-1:0]   r_sq_rem [2];
    logic [16:0]        r_root [2];
    logic [33:0]        r_den;
    logic [32:0]        r_rem;
    logic [16:0]        r_nbits;
    logic [16:0]        r_quo;
    logic               r_sat;
    logic               r_neg;

    logic [IDX_W-1:0]         r_run_count;
    logic signed [ELEM_W-1:0] r_best_score;
    logic [IDX_W-1:0]         r_best_pos;
    logic                     r_have_best;

    logic [2:0] dims_use;

    always_comb begin
        dims_use = (r_dims > 3'(DIM_LIM)) ? 3'(DIM_LIM) : r_dims;
    end
    assign o_stat.n_use = dims_use;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_query[k] <= '0;
            end
            r_dims <= 3'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DIMS) begin
                r_dims <= i_cfg_data[2:0];
            end else if (i_cfg_idx < CFG_DIMS) begin
                r_query[i_cfg_idx[1:0]] <= i_cfg_data;
            end
        end
    end

    // Element-serial accumulation.
    logic signed [ELEM_W-1:0] acc_c, acc_q;
    logic signed [31:0]       p_cq, p_cc, p_qq;

    always_comb begin
        acc_c = r_cand[i_cmd.acc_sel];
        acc_q = r_query[i_cmd.acc_sel];
        p_cq  = acc_c * acc_q;
        p_cc  = acc_c * acc_c;
        p_qq  = acc_q * acc_q;
    end

    // One digit-by-digit square root step per root.
    logic [REM_W+1:0] sq_tmp  [2];
    logic [REM_W+1:0] sq_trial[2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sq_tmp[k]   = {r_sq_rem[k], r_sq_src[k][33:32]};
            sq_trial[k] = (REM_W+2)'({r_root[k], 2'b01});
        end
    end

    // Divider inputs and one restoring step.
    logic [33:0] dot_abs;
    logic [32:0] mag;
    logic [33:0] div_tmp;

    always_comb begin
        dot_abs = r_dot[33] ? 34'(-r_dot) : 34'(r_dot);
        mag     = dot_abs[32:0];
        div_tmp = {r_rem, r_nbits[16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand[0] <= i_cand_elem_0;
            r_cand[1] <= i_cand_elem_1;
            r_cand[2] <= i_cand_elem_2;
            r_cand[3] <= i_cand_elem_3;
            r_last    <= i_last_candidate;
            r_dot     <= '0;
            r_sum[0]  <= '0;
            r_sum[1]  <= '0;
        end
        if (i_cmd.acc) begin
            r_dot    <= r_dot + 34'(p_cq);
            r_sum[0] <= r_sum[0] + 33'($unsigned(p_cc));
            r_sum[1] <= r_sum[1] + 33'($unsigned(p_qq));
        end
        if (i_cmd.sqrt_init) begin
            for (int k = 0; k < 2; k++) begin
                r_sq_src[k] <= {1'b0, r_sum[k]};
                r_sq_rem[k] <= '0;
                r_root[k]   <= '0;
            end
        end
        if (i_cmd.sqrt_step) begin
            for (int k = 0; k < 2; k++) begin
                r_sq_src[k] <= {r_sq_src[k][31:0], 2'b00};
                if (sq_tmp[k] >= sq_trial[k]) begin
                    r_sq_rem[k] <= REM_W'(sq_tmp[k] - sq_trial[k]);
                    r_root[k]   <= {r_root[k][15:0], 1'b1};
                end else begin
                    r_sq_rem[k] <= REM_W'(sq_tmp[k]);
                    r_root[k]   <= {r_root[k][15:0], 1'b0};
                end
            end
        end
        if (i_cmd.mul) begin
            r_den <= 34'(r_root[0] * r_root[1]);
        end
        if (i_cmd.div_init) begin
            // The quotient reaches 2^17 exactly when mag >= 4 * den.
            r_sat   <= {2'b00, mag} >= {r_den[32:0], 2'b00};
            r_neg   <= r_dot[33];
            r_rem   <= {2'b00, mag[32:2]};
            r_nbits <= {mag[1:0], 15'd0};
            r_quo   <= '0;
        end
        if (i_cmd.div_step) begin
            r_nbits <= {r_nbits[15:0], 1'b0};
            if (div_tmp >= r_den) begin
                r_rem <= 33'(div_tmp - r_den);
                r_quo <= {r_quo[15:0], 1'b1};
            end else begin
                r_rem <= div_tmp[32:0];
                r_quo <= {r_quo[15:0], 1'b0};
            end
        end
    end

    // Final similarity and argmax update.
    logic signed [ELEM_W-1:0] sim;
    logic                     better;
    logic                     have_nxt;
    logic [IDX_W-1:0]         pos_nxt;

    always_comb begin
        if (r_root[0] == '0 || r_root[1] == '0) begin
            sim = '0;
        end else if (r_neg) begin
            if (r_sat || r_quo > 17'd32768) begin
                sim = 16'sh8000;
            end else begin
                sim = 16'(-r_quo);
            end
        end else begin
            if (r_sat || r_quo > 17'd32767) begin
                sim = 16'sh7fff;
            end else begin
                sim = r_quo[15:0];
            end
        end
        better   = sim > r_best_score;
        have_nxt = r_have_best | better;
        pos_nxt  = better ? r_run_count : r_best_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count  <= '0;
            r_best_score <= 16'sh8000;
            r_best_pos   <= '0;
            r_have_best  <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_run_count  <= '0;
                r_best_score <= 16'sh8000;
                r_best_pos   <= '0;
                r_have_best  <= 1'b0;
            end else begin
                if (r_run_count < IDX_W'(IDX_LIM)) begin
                    r_run_count <= r_run_count + 1'b1;
                end
                if (better) begin
                    r_best_score <= sim;
                    r_best_pos   <= r_run_count;
                    r_have_best  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_similarity <= sim;
            o_cand_index <= r_run_count;
            o_run_done   <= r_last;
            o_best_index <= have_nxt ? pos_nxt : '0;
            o_best_found <= have_nxt;
        end
    end

endmodule

@@ hw/rtl/cosine_similarity_argmax_core.sv @@
// ----------------------------------------------------------------------------
// cosine_similarity_argmax_core
// Cosine similarity of candidate vectors against a stored query, with a
// running argmax over each run of candidates.
// ----------------------------------------------------------------------------
// Usage: write the query elements (indexes 0 to 3) and the dimension count
// (index 4) through the configuration port while the core is idle. Each
// input transaction carries one candidate vector and a last flag; each one
// produces exactly one output transaction with its similarity, its index in
// the run and the best index found so far in the run.
// Flow: accumulation runs over the dimension count clamped to VEC_DIM and
// four. Two square root units and a restoring divider then each produce a
// 17-bit result, one bit per cycle. One candidate is processed at a time;
// o_in_stall is high while it is in flight, so a new candidate is taken
// only after the previous one has been committed.
// The result sits in an output register, so the next candidate is taken
// while a result still waits. If the receiver keeps i_out_stall high, the
// following candidate finishes and then holds until the register frees up.
// Reset clears the query to zero, the dimension count to four and the run
// state; the core is ready to accept a candidate once reset is released.
// ----------------------------------------------------------------------------
module cosine_similarity_argmax_core
    import cosa_pkg::*;
#(
    parameter int VEC_DIM        = DEF_VEC_DIM,
    parameter int MAX_CANDIDATES = DEF_MAX_CAND
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [ELEM_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [ELEM_W-1:0] i_cand_elem_0,
    input  logic signed [ELEM_W-1:0] i_cand_elem_1,
    input  logic signed [ELEM_W-1:0] i_cand_elem_2,
    input  logic signed [ELEM_W-1:0] i_cand_elem_3,
    input  logic                     i_last_candidate,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [ELEM_W-1:0] o_similarity,
    output logic [IDX_W-1:0]         o_cand_index,
    output logic                     o_run_done,
    output logic [IDX_W-1:0]         o_best_index,
    output logic                     o_best_found
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cosa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cosa_dp #(
        .VEC_DIM        (VEC_DIM),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cand_elem_0    (i_cand_elem_0),
        .i_cand_elem_1    (i_cand_elem_1),
        .i_cand_elem_2    (i_cand_elem_2),
        .i_cand_elem_3    (i_cand_elem_3),
        .i_last_candidate (i_last_candidate),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_similarity     (o_similarity),
        .o_cand_index     (o_cand_index),
        .o_run_done       (o_run_done),
        .o_best_index     (o_best_index),
        .o_best_found     (o_best_found)
    );

endmodule

@@ dv/cosine_similarity_argmax_core_tb.sv @@
// ----------------------------------------------------------------------------
// cosine_similarity_argmax_core_tb
// Self-checking bench: a scoreboard predicts similarity and the running
// argmax for every accepted candidate and compares each output transaction.
// ----------------------------------------------------------------------------
class cosa_scoreboard;
    logic signed [15:0] query [4];
    logic [2:0]         dims;
    logic [7:0]         run_count;
    logic signed [15:0] best_score;
    logic [7:0]         best_pos;
    logic               have_best;
    logic [33:0]        pending [$];
    int                 errors;

    function new();
        for (int i = 0; i < 4; i++) query[i] = '0;
        dims = 3'd4;
        errors = 0;
        clear_run();
    endfunction

    function void clear_run();
        run_count = '0;
        best_score = -16'sd32768;
        best_pos = '0;
        have_best = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
        if (idx < cosa_pkg::CFG_DIMS) query[idx] = data;
        else if (idx == cosa_pkg::CFG_DIMS) dims = data[2:0];
    endfunction

    static function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function void note_candidate(logic signed [15:0] c [4], logic last);
        int n;
        longint dot;
        longint unsigned sc, sq, rc, rq, mag, quo;
        int sim;
        logic [7:0] idx;
        n = (dims > 4) ? 4 : dims;
        dot = 0; sc = 0; sq = 0; sim = 0;
        for (int i = 0; i < n; i++) begin
            dot += longint'(c[i]) * longint'(query[i]);
            sc += longint'(c[i]) * longint'(c[i]);
            sq += longint'(query[i]) * longint'(query[i]);
        end
        rc = floor_sqrt(sc);
        rq = floor_sqrt(sq);
        if (rc != 0 && rq != 0) begin
            mag = (dot < 0) ? longint'(-dot) : dot;
            quo = (mag * 32768) / (rc * rq);
            if (dot < 0) sim = (quo > 32768) ? -32768 : -int'(quo);
            else sim = (quo > 32767) ? 32767 : int'(quo);
        end
        idx = run_count;
        if (run_count < 8'd255) run_count++;
        if (sim > int'(best_score)) begin
            best_score = 16'(sim);
            best_pos = idx;
            have_best = 1'b1;
        end
        pending.push_back({sim[15:0], idx, last, have_best ? best_pos : 8'd0, have_best});
        if (last) clear_run();
    endfunction

    function void check_result(logic [15:0] sim, logic [7:0] idx, logic done,
                               logic [7:0] bidx, logic bfound);
        logic [33:0] exp_r, act;
        act = {sim, idx, done, bidx, bfound};
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, act);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (exp_r !== act) begin
            $display("%0t: mismatch expected sim=%h idx=%0d done=%b best=%0d found=%b",
                     $time, exp_r[33:18], exp_r[17:10], exp_r[9], exp_r[8:1], exp_r[0]);
            $display("%0t:          actual   sim=%h idx=%0d done=%b best=%0d found=%b",
                     $time, sim, idx, done, bidx, bfound);
            errors++;
        end
    endfunction
endclass

module cosine_similarity_argmax_core_tb;
    import cosa_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [ELEM_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [ELEM_W-1:0] i_cand_elem_0 = '0, i_cand_elem_1 = '0;
    logic signed [ELEM_W-1:0] i_cand_elem_2 = '0, i_cand_elem_3 = '0;
    logic i_last_candidate = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [ELEM_W-1:0] o_similarity;
    logic [IDX_W-1:0] o_cand_index, o_best_index;
    logic o_run_done, o_best_found;

    cosa_scoreboard sb = new();

    cosine_similarity_argmax_core i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Drops valid, then waits until all results are back plus some idle time.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_candidate(logic signed [15:0] c [4], logic last, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cand_elem_0 <= c[0];
        i_cand_elem_1 <= c[1];
        i_cand_elem_2 <= c[2];
        i_cand_elem_3 <= c[3];
        i_last_candidate <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_candidate(c, last);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: random stall, checks every accepted result.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_similarity, o_cand_index, o_run_done,
                                o_best_index, o_best_found);
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) i_out_stall <= ($urandom_range(0, 9) < 8);
            else if ($urandom_range(0, 49) == 0) i_out_stall <= 1'b1;
            else i_out_stall <= 1'b0;
        end
    end

    initial begin
        logic signed [15:0] c [4];
        logic signed [15:0] q [4];
        int run_len;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset query (zero norm), then extremes.
        c = '{16'sh0100, 16'sh0200, 16'sh8000, 16'sh7fff};
        send_candidate(c, 1'b0, 1'b0);
        send_candidate(c, 1'b1, 1'b0);
        drain();
        q = '{16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000};
        for (int i = 0; i < 4; i++) write_reg(i[2:0], q[i]);
        write_reg(CFG_DIMS, 16'd4);
        c = '{16'sh0100, 16'sh0, 16'sh0, 16'sh0}; send_candidate(c, 1'b0, 1'b0);
        c = '{16'shff00, 16'sh0, 16'sh0, 16'sh0}; send_candidate(c, 1'b0, 1'b0);
        c = '{16'sh0, 16'sh0, 16'sh0, 16'sh0};    send_candidate(c, 1'b0, 1'b0);
        c = '{16'sh0003, 16'sh0001, 16'sh0, 16'sh0}; send_candidate(c, 1'b0, 1'b0);
        c = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; send_candidate(c, 1'b1, 1'b0);
        // Run of only exact -1.0 values: never best.
        c = '{16'sh8000, 16'sh0, 16'sh0, 16'sh0}; send_candidate(c, 1'b0, 1'b0);
        send_candidate(c, 1'b1, 1'b0);
        drain();
        write_reg(CFG_DIMS, 16'd0);
        c = '{16'sh1234, 16'sh0, 16'sh0, 16'sh0}; send_candidate(c, 1'b1, 1'b0);
        drain();
        write_reg(CFG_DIMS, 16'd7);
        write_reg(3'd5, 16'hffff);
        write_reg(3'd7, 16'hffff);
        c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        for (int i = 0; i < 4; i++) write_reg(i[2:0], 16'h8000);
        send_candidate(c, 1'b0, 1'b0);
        c = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_candidate(c, 1'b1, 1'b0);
        drain();

        // Long run past the index saturation point, with no sender gaps.
        for (int i = 0; i < 300; i++) begin
            for (int k = 0; k < 4; k++) c[k] = rand_elem();
            send_candidate(c, i == 299, 1'b1);
        end

        // Random phases with fresh configuration.
        for (int ph = 0; ph < 20; ph++) begin
            drain();
            for (int i = 0; i < 4; i++) write_reg(i[2:0], rand_elem());
            write_reg(CFG_DIMS, (ph % 5 == 0) ? 16'd1 : 16'($urandom_range(0, 7)));
            for (int n = 0; n < 70; n++) begin
                run_len = $urandom_range(1, 12);
                for (int i = 0; i < 4; i++) c[i] = rand_elem();
                send_candidate(c, (n % 7 == 6) || ($urandom_range(0, run_len) == 0), 1'b0);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
